// File: sv/id3_pkg.sv
`default_nettype none
package id3_pkg;

   localparam int unsigned HdrLen       = 10;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned TagSizeWidth = 28;
   localparam int unsigned SizeWidth    = 32;

   localparam logic [7:0] SyncMask  = 8'h7F;
   localparam logic [7:0] SyncLimit = 8'h80;
   localparam logic [7:0] ByteAllOnes = 8'hFF;
   localparam logic [7:0] CharI     = 8'h49;
   localparam logic [7:0] CharD     = 8'h44;
   localparam logic [7:0] Char3     = 8'h33;
   localparam logic [7:0] MajorV3   = 8'h03;
   localparam logic [7:0] MajorV4   = 8'h04;

   // header byte positions
   localparam logic [CountWidth-1:0] PosI        = 4'd0;
   localparam logic [CountWidth-1:0] PosD        = 4'd1;
   localparam logic [CountWidth-1:0] Pos3        = 4'd2;
   localparam logic [CountWidth-1:0] PosMajor    = 4'd3;
   localparam logic [CountWidth-1:0] PosRevision = 4'd4;
   localparam logic [CountWidth-1:0] PosSizeLo   = 4'd6;
   localparam logic [CountWidth-1:0] PosIdEnd    = 4'd4;
   localparam logic [CountWidth-1:0] PosSizeEnd  = 4'd8;
   localparam logic [CountWidth-1:0] PosHdrLast  = 4'd9;

   typedef enum logic [2:0] {
      ST_PARSING = 3'd0,
      ST_BADHDR  = 3'd1,
      ST_VERSION = 3'd2,
      ST_TRUNC   = 3'd3,
      ST_DONE    = 3'd4
   } status_type;

   typedef enum logic [5:0] {
      PH_TAGHDR  = 6'b000001,
      PH_FRMHDR  = 6'b000010,
      PH_PAYLOAD = 6'b000100,
      PH_SKIP    = 6'b001000,
      PH_DONE    = 6'b010000,
      PH_ERROR   = 6'b100000
   } phase_type;

   localparam logic [3:0] ClsOther   = 4'd0;
   localparam logic [3:0] ClsTitle   = 4'd1;
   localparam logic [3:0] ClsArtist  = 4'd2;
   localparam logic [3:0] ClsAlbum   = 4'd3;
   localparam logic [3:0] ClsGenre   = 4'd4;
   localparam logic [3:0] ClsComment = 4'd5;
   localparam logic [3:0] ClsLength  = 4'd6;
   localparam logic [3:0] ClsYear    = 4'd7;
   localparam logic [3:0] ClsTrack   = 4'd8;
   localparam logic [3:0] ClsPicture = 4'd9;

   localparam logic [31:0] IdTit2 = "TIT2";
   localparam logic [31:0] IdTpe1 = "TPE1";
   localparam logic [31:0] IdTalb = "TALB";
   localparam logic [31:0] IdTcon = "TCON";
   localparam logic [31:0] IdComm = "COMM";
   localparam logic [31:0] IdTlen = "TLEN";
   localparam logic [31:0] IdTdrc = "TDRC";
   localparam logic [31:0] IdTrck = "TRCK";
   localparam logic [31:0] IdApic = "APIC";
   localparam logic [31:0] IdTyer = "TYER";

   function automatic logic [3:0] lookup_class(input logic [31:0] id);
      logic [3:0] cls;
      case (id)
         IdTit2:  cls = ClsTitle;
         IdTpe1:  cls = ClsArtist;
         IdTalb:  cls = ClsAlbum;
         IdTcon:  cls = ClsGenre;
         IdComm:  cls = ClsComment;
         IdTlen:  cls = ClsLength;
         IdTdrc:  cls = ClsYear;
         IdTyer:  cls = ClsYear;
         IdTrck:  cls = ClsTrack;
         IdApic:  cls = ClsPicture;
         default: cls = ClsOther;
      endcase
      return cls;
   endfunction

   function automatic logic id_char_ok(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h30:8'h39]};
   endfunction

endpackage
`default_nettype wire

// File: sv/id3v2_tag_frame_parser_top.sv
`default_nettype none
// Chan Dir Handshake    Fields, each a port behind the channel prefix
// req  in  valid/ready  data_byte[7:0], last_byte
// rsp  out valid/ready  status, frame_class, payload_byte, payload_valid, frame_first, frame_last
//
// One byte per cycle unless rsp stalls: the state updates at the req transfer
// and the result lands in the output register, so rsp_valid follows in the next cycle.
// req_ready is high whenever the output register is empty or is being drained,
// so a stalled rsp holds one result while the block stops taking bytes.
// Synchronous reset returns to the tag header phase; a byte with last set
// also returns the parser to that state after its result.
module id3v2_tag_frame_parser_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [3:0]      rsp_frame_class,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_payload_valid,
   output logic            rsp_frame_first,
   output logic            rsp_frame_last
);

   localparam int unsigned CW = id3_pkg::CountWidth;
   localparam int unsigned TW = id3_pkg::TagSizeWidth;
   localparam int unsigned SW = id3_pkg::SizeWidth;

   // parser state
   id3_pkg::phase_type  phase_ff, phase_in;
   id3_pkg::status_type fstat_ff, fstat_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TW-1:0] tag_rem_ff, tag_rem_in;
   logic [TW-1:0] frm_rem_ff, frm_rem_in;   // never exceeds the tag size
   logic          is_v4_ff, is_v4_in;
   logic [31:0]   id_ff, id_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [3:0]    cls_ff, cls_in;

   // output register
   logic       rsp_valid_ff;
   logic [2:0] status_ff, status_in;
   logic [3:0] ocls_ff, ocls_in;
   logic [7:0] obyte_ff, obyte_in;
   logic       opv_ff, opv_in;
   logic       ofirst_ff, ofirst_in;
   logic       olast_ff, olast_in;

   logic          accept;
   logic [TW-1:0] tag_dec;
   logic [TW-1:0] frm_dec;
   logic          bnd_en;       // frame boundary reached
   logic [TW-1:0] bnd_tag;
   logic          hdr_bad;
   logic          ids_ok;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign tag_dec   = tag_rem_ff - TW'(1);
   assign frm_dec   = frm_rem_ff - TW'(1);

   assign ids_ok = id3_pkg::id_char_ok(id_ff[31:24]) && id3_pkg::id_char_ok(id_ff[23:16]) &&
                   id3_pkg::id_char_ok(id_ff[15:8])  && id3_pkg::id_char_ok(id_ff[7:0]);

   assign hdr_bad = (count_ff == id3_pkg::PosI && req_data_byte != id3_pkg::CharI) ||
                    (count_ff == id3_pkg::PosD && req_data_byte != id3_pkg::CharD) ||
                    (count_ff == id3_pkg::Pos3 && req_data_byte != id3_pkg::Char3) ||
                    ((count_ff == id3_pkg::PosMajor || count_ff == id3_pkg::PosRevision) &&
                     req_data_byte == id3_pkg::ByteAllOnes) ||
                    (count_ff >= id3_pkg::PosSizeLo && req_data_byte >= id3_pkg::SyncLimit);

   always_comb begin
      phase_in   = phase_ff;
      fstat_in   = fstat_ff;
      count_in   = count_ff;
      tag_rem_in = tag_rem_ff;
      frm_rem_in = frm_rem_ff;
      is_v4_in   = is_v4_ff;
      id_in      = id_ff;
      acc_in     = acc_ff;
      cls_in     = cls_ff;
      bnd_en     = 1'b0;
      bnd_tag    = tag_rem_ff;
      ocls_in    = id3_pkg::ClsOther;
      obyte_in   = 8'h00;
      opv_in     = 1'b0;
      ofirst_in  = 1'b0;
      olast_in   = 1'b0;

      case (phase_ff)
         id3_pkg::PH_TAGHDR: begin
            if (hdr_bad) begin
               fstat_in = id3_pkg::ST_BADHDR;
            end
            if (count_ff == id3_pkg::PosMajor && req_data_byte != id3_pkg::ByteAllOnes) begin
               is_v4_in = (req_data_byte == id3_pkg::MajorV4);
               if (req_data_byte != id3_pkg::MajorV3 && req_data_byte != id3_pkg::MajorV4 &&
                   fstat_in == id3_pkg::ST_PARSING) begin
                  fstat_in = id3_pkg::ST_VERSION;
               end
            end
            if (count_ff >= id3_pkg::PosSizeLo) begin
               acc_in = {4'b0000, acc_ff[20:0], req_data_byte[6:0] & id3_pkg::SyncMask[6:0]};
            end
            if (count_ff != id3_pkg::PosHdrLast) begin
               count_in = count_ff + CW'(1);
            end else if (fstat_in != id3_pkg::ST_PARSING) begin
               phase_in = id3_pkg::PH_ERROR;
            end else begin
               tag_rem_in = acc_in[TW-1:0];
               bnd_en     = 1'b1;
               bnd_tag    = acc_in[TW-1:0];
            end
         end
         id3_pkg::PH_FRMHDR: begin
            tag_rem_in = tag_dec;
            if (count_ff < id3_pkg::PosIdEnd) begin
               id_in = {id_ff[23:0], req_data_byte};
            end else if (count_ff < id3_pkg::PosSizeEnd) begin
               if (is_v4_ff) begin
                  acc_in = {acc_ff[SW-8:0], req_data_byte[6:0]};
               end else begin
                  acc_in = {acc_ff[SW-9:0], req_data_byte};
               end
            end
            if (count_ff != id3_pkg::PosHdrLast) begin
               count_in = count_ff + CW'(1);
            end else if (!ids_ok || acc_ff == '0 || acc_ff > SW'(tag_dec)) begin
               // padding or bad ID, empty or oversized frame: consume rest of tag quietly
               if (tag_dec == '0) begin
                  phase_in = id3_pkg::PH_DONE;
                  fstat_in = id3_pkg::ST_DONE;
               end else begin
                  phase_in = id3_pkg::PH_SKIP;
               end
            end else begin
               cls_in     = id3_pkg::lookup_class(id_ff);
               frm_rem_in = acc_ff[TW-1:0];
               count_in   = '0;
               phase_in   = id3_pkg::PH_PAYLOAD;
            end
         end
         id3_pkg::PH_PAYLOAD: begin
            if (cls_ff != id3_pkg::ClsOther) begin
               ocls_in   = cls_ff;
               obyte_in  = req_data_byte;
               opv_in    = 1'b1;
               ofirst_in = (count_ff == '0);
               olast_in  = (frm_rem_ff == TW'(1));
            end
            count_in   = CW'(1);
            tag_rem_in = tag_dec;
            frm_rem_in = frm_dec;
            if (frm_dec == '0) begin
               bnd_en  = 1'b1;
               bnd_tag = tag_dec;
            end
         end
         id3_pkg::PH_SKIP: begin
            tag_rem_in = tag_dec;
            if (tag_dec == '0) begin
               phase_in = id3_pkg::PH_DONE;
               fstat_in = id3_pkg::ST_DONE;
            end
         end
         default: begin
         end
      endcase

      if (bnd_en) begin
         if (bnd_tag == '0) begin
            phase_in = id3_pkg::PH_DONE;
            fstat_in = id3_pkg::ST_DONE;
         end else if (bnd_tag < TW'(id3_pkg::HdrLen)) begin
            phase_in = id3_pkg::PH_SKIP;
         end else begin
            phase_in = id3_pkg::PH_FRMHDR;
            count_in = '0;
            id_in    = '0;
            acc_in   = '0;
         end
      end

      if (req_last_byte) begin
         if (phase_in == id3_pkg::PH_DONE || phase_in == id3_pkg::PH_ERROR) begin
            status_in = fstat_in;
         end else begin
            status_in = id3_pkg::ST_TRUNC;
         end
      end else if (phase_in == id3_pkg::PH_TAGHDR) begin
         status_in = id3_pkg::ST_PARSING;
      end else begin
         status_in = fstat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= id3_pkg::PH_TAGHDR;
         fstat_ff     <= id3_pkg::ST_PARSING;
         count_ff     <= '0;
         tag_rem_ff   <= '0;
         frm_rem_ff   <= '0;
         is_v4_ff     <= 1'b0;
         id_ff        <= '0;
         acc_ff       <= '0;
         cls_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            if (req_last_byte) begin
               // rearm for the next tag
               phase_ff   <= id3_pkg::PH_TAGHDR;
               fstat_ff   <= id3_pkg::ST_PARSING;
               count_ff   <= '0;
               tag_rem_ff <= '0;
               frm_rem_ff <= '0;
               is_v4_ff   <= 1'b0;
               id_ff      <= '0;
               acc_ff     <= '0;
               cls_ff     <= '0;
            end else begin
               phase_ff   <= phase_in;
               fstat_ff   <= fstat_in;
               count_ff   <= count_in;
               tag_rem_ff <= tag_rem_in;
               frm_rem_ff <= frm_rem_in;
               is_v4_ff   <= is_v4_in;
               id_ff      <= id_in;
               acc_ff     <= acc_in;
               cls_ff     <= cls_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         ocls_ff   <= ocls_in;
         obyte_ff  <= obyte_in;
         opv_ff    <= opv_in;
         ofirst_ff <= ofirst_in;
         olast_ff  <= olast_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_frame_class   = ocls_ff;
   assign rsp_payload_byte  = obyte_ff;
   assign rsp_payload_valid = opv_ff;
   assign rsp_frame_first   = ofirst_ff;
   assign rsp_frame_last    = olast_ff;

   // non-payload results carry zeroed frame fields
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !opv_ff) |-> (ocls_ff == '0 && !ofirst_ff && !olast_ff && obyte_ff == '0))
      else $error("frame fields set without payload_valid");

   a_error_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == id3_pkg::PH_ERROR) |->
      (fstat_ff == id3_pkg::ST_BADHDR || fstat_ff == id3_pkg::ST_VERSION))
      else $error("error phase without header error status");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == id3_pkg::PH_DONE) |-> (fstat_ff == id3_pkg::ST_DONE))
      else $error("done phase without done status");

   a_frame_fits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == id3_pkg::PH_PAYLOAD) |-> (frm_rem_ff != '0 && frm_rem_ff <= tag_rem_ff))
      else $error("frame overruns tag");

endmodule
`default_nettype wire

// File: tb/tb_id3v2_tag_frame_parser_top.sv
`timescale 1ns / 100ps

module tb_id3v2_tag_frame_parser_top;

   // ---------------------------------------------------------------------------
   // Run constants
   // ---------------------------------------------------------------------------
   localparam int ItemsPerPhase = 385;   // minimum random bytes per traffic phase, whole tags
   localparam int HoldOffCycles = 300;   // long rsp back-pressure burst
   localparam int WatchdogLimit = 2000;  // cycles with no transfer at all
   localparam int DrainCycles   = 10;    // settle time after the last result
   localparam int DirectedLen   = 33;

   // one result transfer, field for field
   typedef struct packed {
      logic [2:0] status;
      logic [3:0] frame_class;
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       frame_first;
      logic       frame_last;
   } parse_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stim_byte_type;

   // directed row: byte, last flag, and a hand-typed result where typed is set
   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic             typed;
      parse_result_type want;
   } directed_row_type;

   typedef enum {
      TRAFFIC_FREE,
      TRAFFIC_SEND_GAPS,
      TRAFFIC_RECV_STALLS,
      TRAFFIC_BOTH
   } traffic_mode_type;

   localparam parse_result_type ResQuiet =
      '{id3_pkg::ST_PARSING, id3_pkg::ClsOther, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam parse_result_type ResDone  =
      '{id3_pkg::ST_DONE,    id3_pkg::ClsOther, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam parse_result_type ResTrunc =
      '{id3_pkg::ST_TRUNC,   id3_pkg::ClsOther, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam parse_result_type ResBad   =
      '{id3_pkg::ST_BADHDR,  id3_pkg::ClsOther, 8'h00, 1'b0, 1'b0, 1'b0};
   localparam parse_result_type ResTitle =
      '{id3_pkg::ST_DONE,    id3_pkg::ClsTitle, 8'hFF, 1'b1, 1'b1, 1'b1};

   // ---------------------------------------------------------------------------
   // Directed table
   //   v4 tag, size 11, one TIT2 frame of one byte; its size field has bit 7
   //   set in the top byte, which must be ignored. Then one byte beyond the
   //   tag end, an early end inside a fresh header, and a header with an
   //   all-ones major version byte.
   // ---------------------------------------------------------------------------
   directed_row_type directed_rows [DirectedLen] = '{
      '{8'h49, 1'b0, 1'b1, ResQuiet},
      '{8'h44, 1'b0, 1'b1, ResQuiet},
      '{8'h33, 1'b0, 1'b1, ResQuiet},
      '{8'h04, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h0B, 1'b0, 1'b1, ResQuiet},
      // frame header: left to the predictor
      '{8'h54, 1'b0, 1'b0, ResQuiet},
      '{8'h49, 1'b0, 1'b0, ResQuiet},
      '{8'h54, 1'b0, 1'b0, ResQuiet},
      '{8'h32, 1'b0, 1'b0, ResQuiet},
      '{8'h80, 1'b0, 1'b0, ResQuiet},
      '{8'h00, 1'b0, 1'b0, ResQuiet},
      '{8'h00, 1'b0, 1'b0, ResQuiet},
      '{8'h01, 1'b0, 1'b0, ResQuiet},
      '{8'h00, 1'b0, 1'b0, ResQuiet},
      '{8'h00, 1'b0, 1'b0, ResQuiet},
      // only payload byte: first and last at once, tag used up
      '{8'hFF, 1'b0, 1'b1, ResTitle},
      // past the tag end, stays done
      '{8'h00, 1'b1, 1'b1, ResDone},
      // end of data on the first header byte
      '{8'h00, 1'b1, 1'b1, ResTrunc},
      // major version 0xFF
      '{8'h49, 1'b0, 1'b1, ResQuiet},
      '{8'h44, 1'b0, 1'b1, ResQuiet},
      '{8'h33, 1'b0, 1'b1, ResQuiet},
      '{8'hFF, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b0, 1'b1, ResQuiet},
      '{8'h00, 1'b1, 1'b1, ResBad}
   };

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT ports. Every input starts at a known value.
   // ---------------------------------------------------------------------------
   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_ready     = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [2:0] rsp_status;
   logic [3:0] rsp_frame_class;
   logic [7:0] rsp_payload_byte;
   logic       rsp_payload_valid;
   logic       rsp_frame_first;
   logic       rsp_frame_last;

   // side info travelling with the byte on req: hand-typed result, if any
   logic             note_typed = 1'b0;
   parse_result_type note_want  = '0;

   // traffic shaping knobs, percent per cycle
   int   gap_pct   = 0;
   int   stall_pct = 0;
   logic hold_off  = 1'b0;

   int mismatches = 0;
   int idle_count = 0;

   parse_result_type pending_results [$];  // expected rsp transfers, oldest first
   stim_byte_type    tag_stream [$];       // bytes of the next generated tag
   logic [7:0]       tag_body [$];         // frame area being assembled

   initial begin
      forever #1 clock = ~clock;
   end

   id3v2_tag_frame_parser_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_frame_class   (rsp_frame_class),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_frame_first   (rsp_frame_first),
      .rsp_frame_last    (rsp_frame_last)
   );

   // ---------------------------------------------------------------------------
   // Parser mirror: own copy of the walk state
   // ---------------------------------------------------------------------------
   id3_pkg::phase_type  ph;
   logic [3:0]          hdr_idx;    // byte index in a header; 1 once payload started
   logic [27:0]         tag_left;   // tag bytes still due after the tag header
   logic [31:0]         frm_left;   // payload bytes left in the frame
   logic                v4;
   logic [31:0]         id_word;
   logic [31:0]         size_acc;
   logic [3:0]          cur_cls;
   id3_pkg::status_type outcome;

   function automatic void clear_parser();
      ph       = id3_pkg::PH_TAGHDR;
      hdr_idx  = '0;
      tag_left = '0;
      frm_left = '0;
      v4       = 1'b0;
      id_word  = '0;
      size_acc = '0;
      cur_cls  = id3_pkg::ClsOther;
      outcome  = id3_pkg::ST_PARSING;
   endfunction

   function automatic logic is_id_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
   endfunction

   function automatic logic [3:0] frame_class_of(input logic [31:0] id);
      if (id == id3_pkg::IdTit2) return id3_pkg::ClsTitle;
      if (id == id3_pkg::IdTpe1) return id3_pkg::ClsArtist;
      if (id == id3_pkg::IdTalb) return id3_pkg::ClsAlbum;
      if (id == id3_pkg::IdTcon) return id3_pkg::ClsGenre;
      if (id == id3_pkg::IdComm) return id3_pkg::ClsComment;
      if (id == id3_pkg::IdTlen) return id3_pkg::ClsLength;
      if (id == id3_pkg::IdTdrc || id == id3_pkg::IdTyer) return id3_pkg::ClsYear;
      if (id == id3_pkg::IdTrck) return id3_pkg::ClsTrack;
      if (id == id3_pkg::IdApic) return id3_pkg::ClsPicture;
      return id3_pkg::ClsOther;
   endfunction

   // next frame header, skip of a short tail, or tag end
   function automatic void enter_frame_boundary();
      if (tag_left == 0) begin
         ph      = id3_pkg::PH_DONE;
         outcome = id3_pkg::ST_DONE;
      end else if (tag_left < id3_pkg::HdrLen) begin
         ph = id3_pkg::PH_SKIP;
      end else begin
         ph       = id3_pkg::PH_FRMHDR;
         hdr_idx  = '0;
         id_word  = '0;
         size_acc = '0;
      end
   endfunction

   // one accepted byte in, the result it causes out
   function automatic parse_result_type parse_byte(input logic [7:0] b, input logic lst);
      parse_result_type r;
      logic [3:0]       i;
      r = '0;
      i = hdr_idx;
      case (ph)
         id3_pkg::PH_TAGHDR: begin
            if ((i == id3_pkg::PosI && b != id3_pkg::CharI) ||
                (i == id3_pkg::PosD && b != id3_pkg::CharD) ||
                (i == id3_pkg::Pos3 && b != id3_pkg::Char3) ||
                ((i == id3_pkg::PosMajor || i == id3_pkg::PosRevision) &&
                 b == id3_pkg::ByteAllOnes) ||
                (i >= id3_pkg::PosSizeLo && b >= id3_pkg::SyncLimit))
               outcome = id3_pkg::ST_BADHDR;
            if (i == id3_pkg::PosMajor && b != id3_pkg::ByteAllOnes) begin
               v4 = (b == id3_pkg::MajorV4);
               if (b != id3_pkg::MajorV3 && b != id3_pkg::MajorV4 &&
                   outcome == id3_pkg::ST_PARSING)
                  outcome = id3_pkg::ST_VERSION;
            end
            if (i >= id3_pkg::PosSizeLo)
               size_acc = {4'h0, size_acc[20:0], b[6:0]};
            if (i < id3_pkg::PosHdrLast) begin
               hdr_idx = i + 4'd1;
            end else if (outcome != id3_pkg::ST_PARSING) begin
               ph = id3_pkg::PH_ERROR;
            end else begin
               tag_left = size_acc[27:0];
               enter_frame_boundary();
            end
         end
         id3_pkg::PH_FRMHDR: begin
            tag_left = tag_left - 28'd1;
            if (i < id3_pkg::PosIdEnd)
               id_word = {id_word[23:0], b};
            else if (i < id3_pkg::PosSizeEnd)
               size_acc = v4 ? {size_acc[24:0], b[6:0]} : {size_acc[23:0], b};
            if (i < id3_pkg::PosHdrLast) begin
               hdr_idx = i + 4'd1;
            end else if (!is_id_char(id_word[31:24]) || !is_id_char(id_word[23:16]) ||
                         !is_id_char(id_word[15:8]) || !is_id_char(id_word[7:0]) ||
                         size_acc == 0 || size_acc > {4'h0, tag_left}) begin
               // clean stop: swallow the rest of the tag
               if (tag_left == 0) begin
                  ph      = id3_pkg::PH_DONE;
                  outcome = id3_pkg::ST_DONE;
               end else begin
                  ph = id3_pkg::PH_SKIP;
               end
            end else begin
               cur_cls  = frame_class_of(id_word);
               frm_left = size_acc;
               hdr_idx  = '0;
               ph       = id3_pkg::PH_PAYLOAD;
            end
         end
         id3_pkg::PH_PAYLOAD: begin
            if (cur_cls != id3_pkg::ClsOther) begin
               r.frame_class   = cur_cls;
               r.payload_byte  = b;
               r.payload_valid = 1'b1;
               r.frame_first   = (hdr_idx == 0);
               r.frame_last    = (frm_left == 1);
            end
            hdr_idx  = 4'd1;
            tag_left = tag_left - 28'd1;
            frm_left = frm_left - 32'd1;
            if (frm_left == 0)
               enter_frame_boundary();
         end
         id3_pkg::PH_SKIP: begin
            tag_left = tag_left - 28'd1;
            if (tag_left == 0) begin
               ph      = id3_pkg::PH_DONE;
               outcome = id3_pkg::ST_DONE;
            end
         end
         default: ;
      endcase

      if (lst)
         r.status = (ph == id3_pkg::PH_DONE || ph == id3_pkg::PH_ERROR) ?
                    outcome : id3_pkg::ST_TRUNC;
      else
         r.status = (ph == id3_pkg::PH_TAGHDR) ? id3_pkg::ST_PARSING : outcome;
      if (lst)
         clear_parser();
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Tag generator
   // ---------------------------------------------------------------------------
   function automatic logic [7:0] rand_id_char();
      int unsigned k;
      k = $urandom_range(35);
      return (k < 26) ? 8'("A" + k) : 8'("0" + k - 26);
   endfunction

   function automatic logic [31:0] pick_frame_id();
      logic [31:0] known [10];
      logic [31:0] fid;
      int          n;
      known = '{id3_pkg::IdTit2, id3_pkg::IdTpe1, id3_pkg::IdTalb, id3_pkg::IdTcon,
                id3_pkg::IdComm, id3_pkg::IdTlen, id3_pkg::IdTdrc, id3_pkg::IdTrck,
                id3_pkg::IdApic, id3_pkg::IdTyer};
      if ($urandom_range(99) < 70)
         return known[$urandom_range(9)];
      for (n = 0; n < 4; n++)
         fid[8*n +: 8] = rand_id_char();
      return fid;
   endfunction

   // v4 sizes are synchsafe, bit 7 of each byte is don't-care and randomized
   function automatic void add_frame_header(input logic [31:0] fid, input logic [31:0] fsize,
                                            input logic sync);
      int n;
      for (n = 3; n >= 0; n--)
         tag_body.push_back(fid[8*n +: 8]);
      for (n = 3; n >= 0; n--) begin
         if (sync)
            tag_body.push_back({($urandom_range(3) == 0), fsize[7*n +: 7]});
         else
            tag_body.push_back(fsize[8*n +: 8]);
      end
      tag_body.push_back(8'($urandom_range(255)));
      tag_body.push_back(8'($urandom_range(255)));
   endfunction

   // Mostly well-formed tags with random content; a share of broken headers,
   // clean-stop tails, size mismatches, early ends, trailing junk and noise.
   task automatic build_tag();
      logic [7:0]  stream_bytes [$];
      logic [7:0]  major;
      logic [7:0]  rev;
      logic [31:0] fid;
      logic [27:0] tag_size;
      int unsigned nframes, fsize, total, pick, cut, k, j;
      int          n;
      tag_body     = {};
      stream_bytes = {};
      if ($urandom_range(99) < 5) begin
         // noise, sometimes with a plausible start
         if ($urandom_range(1))
            stream_bytes = {id3_pkg::CharI, id3_pkg::CharD, id3_pkg::Char3};
         repeat ($urandom_range(1, 12))
            stream_bytes.push_back(8'($urandom_range(255)));
      end else begin
         pick = $urandom_range(99);
         if (pick < 45)
            major = id3_pkg::MajorV3;
         else if (pick < 92)
            major = id3_pkg::MajorV4;
         else
            major = 8'($urandom_range(255));

         nframes = $urandom_range(4);
         for (k = 0; k < nframes; k++) begin
            pick = $urandom_range(99);
            if (pick < 85)
               fsize = $urandom_range(1, 10);
            else if (pick < 97)
               fsize = $urandom_range(11, 60);
            else
               fsize = 0;
            add_frame_header(pick_frame_id(), fsize, major == id3_pkg::MajorV4);
            for (j = 0; j < fsize; j++)
               tag_body.push_back(8'($urandom_range(255)));
         end

         pick = $urandom_range(99);
         if (pick < 25) begin
            // padding; short runs end up skipped, long ones hit a zero ID
            repeat ($urandom_range(1, 12))
               tag_body.push_back(8'h00);
         end else if (pick < 35) begin
            fid = pick_frame_id();
            if ($urandom_range(1)) begin
               fid[8*$urandom_range(3) +: 8] =
                  $urandom_range(1) ? 8'h00 : 8'("a" + $urandom_range(25));
               add_frame_header(fid, $urandom_range(1, 4), major == id3_pkg::MajorV4);
            end else begin
               // frame claims more than the tag holds
               add_frame_header(fid, 32'($urandom) | 32'h0000_0100,
                                major == id3_pkg::MajorV4);
            end
            repeat ($urandom_range(1, 6))
               tag_body.push_back(8'($urandom_range(255)));
         end

         total = tag_body.size();
         pick  = $urandom_range(99);
         if (pick < 80) begin
            tag_size = 28'(total);
         end else if (pick < 88) begin
            // short tail after the frames
            tag_size = 28'(total + $urandom_range(1, 9));
            while (tag_body.size() < tag_size)
               tag_body.push_back(8'($urandom_range(255)));
         end else if (pick < 96) begin
            tag_size = (total > 8) ? 28'(total - $urandom_range(1, 8)) : 28'd0;
         end else if (pick < 98) begin
            tag_size = '0;
         end else begin
            tag_size = '1;
         end

         rev = ($urandom_range(29) == 0) ? id3_pkg::ByteAllOnes : 8'($urandom_range(254));
         stream_bytes = {id3_pkg::CharI, id3_pkg::CharD, id3_pkg::Char3, major, rev,
                         8'($urandom_range(255)),
                         {1'b0, tag_size[27:21]}, {1'b0, tag_size[20:14]},
                         {1'b0, tag_size[13:7]}, {1'b0, tag_size[6:0]}};
         if ($urandom_range(99) < 6)
            stream_bytes[$urandom_range(9)] = 8'($urandom_range(255));
         foreach (tag_body[n])
            stream_bytes.push_back(tag_body[n]);

         pick = $urandom_range(99);
         if (pick < 8) begin
            // early end somewhere inside the stream
            cut          = $urandom_range(1, stream_bytes.size());
            stream_bytes = stream_bytes[0:cut-1];
         end else if (pick < 15) begin
            repeat ($urandom_range(1, 4))
               stream_bytes.push_back(8'($urandom_range(255)));
         end
      end

      for (n = 0; n < stream_bytes.size(); n++)
         tag_stream.push_back('{stream_bytes[n], n == stream_bytes.size() - 1});
   endtask

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------
   // Offer one byte and hold it until the transfer. A back-to-back byte is
   // driven in the step of the previous transfer, so valid is never toggled
   // twice in one step.
   task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                            input parse_result_type want);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      note_typed    <= typed;
      note_want     <= want;
      @(posedge clock);
      while (!(req_valid && req_ready))
         @(posedge clock);
   endtask

   // Stop offering and wait until every expected result has been taken.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side: random stalls, plus one long hold-off on request. The
   // hold-off is counted here so the sender keeps offering and the block
   // fills up and drops req_ready.
   // ---------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off  <= 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Scoreboard. All TB drives are nonblocking, so at the edge every signal
   // read here still holds its pre-edge value.
   // ---------------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      parse_result_type w;
      if (reset) begin
         clear_parser();
      end else begin
         // result first, so a stray result can't match a new expectation
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no expectation pending");
               mismatches++;
            end else begin
               w = pending_results.pop_front();
               compare_field("status",        8'(w.status),        8'(rsp_status));
               compare_field("frame_class",   8'(w.frame_class),   8'(rsp_frame_class));
               compare_field("payload_byte",  w.payload_byte,      rsp_payload_byte);
               compare_field("payload_valid", 8'(w.payload_valid), 8'(rsp_payload_valid));
               compare_field("frame_first",   8'(w.frame_first),   8'(rsp_frame_first));
               compare_field("frame_last",    8'(w.frame_last),    8'(rsp_frame_last));
            end
         end
         if (req_valid && req_ready) begin
            w = parse_byte(req_data_byte, req_last_byte);
            // hand-typed rows override, the mirror still advances
            if (note_typed)
               w = note_want;
            pending_results.push_back(w);
         end
      end
   end

   // Watchdog: too long without a transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      traffic_mode_type mode;
      stim_byte_type    s;
      int               n;
      int               sent;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, free-flowing traffic
      for (n = 0; n < DirectedLen; n++)
         send_byte(directed_rows[n].data, directed_rows[n].last, directed_rows[n].typed,
                   directed_rows[n].want);
      wait_results_drained();

      // random tags under each traffic mode; drain fully between modes
      for (n = 0; n < 4; n++) begin
         mode = traffic_mode_type'(n);
         case (mode)
            TRAFFIC_FREE: begin
               gap_pct   = 0;
               stall_pct = 0;
               hold_off <= 1'b1;
            end
            TRAFFIC_SEND_GAPS: begin
               gap_pct   = 78;
               stall_pct = 0;
            end
            TRAFFIC_RECV_STALLS: begin
               gap_pct   = 0;
               stall_pct = 78;
            end
            default: begin
               gap_pct   = 10;
               stall_pct = 10;
            end
         endcase
         sent = 0;
         while (sent < ItemsPerPhase) begin
            build_tag();
            while (tag_stream.size() != 0) begin
               s = tag_stream.pop_front();
               send_byte(s.data, s.last, 1'b0, ResQuiet);
               sent++;
            end
         end
         wait_results_drained();
      end

      // anything arriving now is a stray result
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
